### sv/direct_dft_bin_accumulator_top_defines.svh
// Assertion macros shared by the DFT bin accumulator RTL.
`ifndef DIRECT_DFT_BIN_ACCUMULATOR_TOP_DEFINES_SVH
`define DIRECT_DFT_BIN_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DDFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DDFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ddft_pkg.sv
// Constants, types and twiddle generation for the DFT bin accumulator.
package ddft_pkg;

  localparam int FRAME_POINTS_DEF = 64;
  localparam int SAMPLE_W         = 16;
  localparam int TW_W             = 16;
  localparam int SUM_W            = 40;
  localparam int SCALE_W          = 32;
  localparam int BIN_IDX_W        = 6;
  localparam int OUT_SHIFT        = 31;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

  localparam int    CORDIC_STEPS = 16;
  localparam longint CORDIC_START = 64'sd652032874;
  localparam longint TURN_ATAN [CORDIC_STEPS] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
    64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
    64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
    64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D
  };

  typedef struct packed {
    logic signed [TW_W-1:0] cos_v;
    logic signed [TW_W-1:0] sin_v;
  } twid_t;

  // Round half up to Q1.15 and clamp.
  function automatic longint q15_round(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  // cos/sin of a phase given in 2^32 turns; 16-step CORDIC with floor shifts.
  function automatic twid_t twiddle(input logic [31:0] phase);
    logic [31:0] q;
    logic [31:0] ru;
    longint      z;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      xr;
    longint      yr;
    longint      c;
    longint      s;
    twid_t       t;
    q  = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    ru = phase - (q << 30);
    z  = longint'($signed(ru));
    x  = CORDIC_START;
    y  = 64'sd0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - TURN_ATAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + TURN_ATAN[i];
      end
    end
    xr = q15_round(x);
    yr = q15_round(y);
    case (q[1:0])
      2'd0: begin
        c = xr;
        s = yr;
      end
      2'd1: begin
        c = -yr;
        s = xr;
      end
      2'd2: begin
        c = -xr;
        s = -yr;
      end
      default: begin
        c = yr;
        s = -xr;
      end
    endcase
    if (c > 64'sd32767) c = 64'sd32767;
    if (s > 64'sd32767) s = 64'sd32767;
    t.cos_v = TW_W'(c);
    t.sin_v = TW_W'(s);
    return t;
  endfunction

endpackage

### sv/ddft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ddft_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/direct_dft_bin_accumulator_top.sv
// Direct DFT bin accumulator: per-sample update of FRAME_POINTS/2 complex bins, framed readout.
//
// Each accepted item (start high while busy low) carries one signed Q1.15
// sample. Sample n of a frame is multiplied by cos/sin of 2*pi*m*n/FRAME_POINTS
// and added into every bin m below FRAME_POINTS/2 (real += x*cos,
// imag -= x*sin, 40-bit saturating sums). A frame is FRAME_POINTS+1 samples.
// The bins live in one RAM (real and imag side by side) that is read, updated
// and written back one bin per cycle; busy stays high through the whole bin
// pass, so a new sample is taken only once the last one is through, and that
// single bin pass is what sets the rate. For the sample that closes a frame,
// the updated sums also go through a two-stage scale pipeline
// (sum * scale_factor / 2^31, floored, saturated to 40 bits) and the
// FRAME_POINTS/2 bins come out on consecutive cycles, one per cycle with
// out_valid high, out_last_bin marking the final one. The receiver cannot
// stall: every result is shown for exactly one cycle. The closing sample
// writes zeros back, so the next frame starts clean; a valid bit per bin
// makes bins read as zero after reset without a clearing pass. The sample
// counter restarts at zero. scale_factor resets to 1.0 (0x10000) and is
// written through cfg_wr_en/cfg_wr_data; write it only while busy is low.
// bin_index carries the low 6 bits of the bin number.
`include "direct_dft_bin_accumulator_top_defines.svh"

module direct_dft_bin_accumulator_top #(
  parameter int FRAME_POINTS = ddft_pkg::FRAME_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample_value,
  // scale register
  input  logic                                 cfg_wr_en,
  input  logic [ddft_pkg::SCALE_W-1:0]         cfg_wr_data,
  // result channel
  output logic                                 out_valid,
  output logic [ddft_pkg::BIN_IDX_W-1:0]       out_bin_index,
  output logic signed [ddft_pkg::SUM_W-1:0]    out_real_part,
  output logic signed [ddft_pkg::SUM_W-1:0]    out_imag_part,
  output logic                                 out_last_bin
);

  localparam int BIN_COUNT = FRAME_POINTS / 2;
  localparam int BIN_AW    = $clog2(BIN_COUNT);
  localparam int K_W       = $clog2(FRAME_POINTS);
  localparam int CNT_W     = $clog2(FRAME_POINTS + 1);
  localparam int SW        = ddft_pkg::SUM_W;
  localparam int PW        = 2 * ddft_pkg::SAMPLE_W;
  localparam int HALF_W    = ddft_pkg::SCALE_W / 2;
  localparam int MW        = SW + HALF_W + 1;            // sum * 17-bit half
  localparam int TOT_W     = SW + ddft_pkg::SCALE_W + 1; // full sum * scale

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // ---------------------------------------------------------------------
  // Twiddle table: constant, built at elaboration from the CORDIC function.
  // ---------------------------------------------------------------------
  ddft_pkg::twid_t tw_tab [FRAME_POINTS];

  for (genvar gk = 0; gk < FRAME_POINTS; gk++) begin : g_tw
    localparam logic [63:0] PHASE =
      ((64'(gk) << 32) + 64'(FRAME_POINTS / 2)) / 64'(FRAME_POINTS);
    assign tw_tab[gk] = ddft_pkg::twiddle(PHASE[31:0]);
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_t                       state_r;
  logic [CNT_W-1:0]             n_r;           // samples taken in this frame
  logic [BIN_AW-1:0]            rd_m_r;        // bin being read
  logic [K_W-1:0]               k_r;           // (m*n) mod FRAME_POINTS
  logic                         frame_last_r;  // current sample closes a frame
  logic [BIN_COUNT-1:0]         mem_vld_r;     // bin written since reset
  logic [ddft_pkg::SCALE_W-1:0] scale_factor_r;
  logic                         s1_vld_r;
  logic                         s2_vld_r;
  logic                         s3_vld_r;
  logic                         out_valid_r;

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  logic signed [ddft_pkg::SAMPLE_W-1:0] sample_r;
  logic [K_W-1:0]                       stride_r;     // n mod FRAME_POINTS
  logic [BIN_AW-1:0]                    s1_m_r;
  logic                                 s1_ent_vld_r;
  logic signed [PW-1:0]                 s1_re_prod_r;
  logic signed [PW-1:0]                 s1_im_prod_r;
  logic [BIN_AW-1:0]                    s2_m_r;
  logic signed [SW-1:0]                 s2_re_r;
  logic signed [SW-1:0]                 s2_im_r;
  logic [BIN_AW-1:0]                    s3_m_r;
  logic signed [MW-1:0]                 s3_re_hi_r;
  logic signed [MW-1:0]                 s3_re_lo_r;
  logic signed [MW-1:0]                 s3_im_hi_r;
  logic signed [MW-1:0]                 s3_im_lo_r;
  logic [ddft_pkg::BIN_IDX_W-1:0]       out_bin_index_r;
  logic signed [SW-1:0]                 out_real_r;
  logic signed [SW-1:0]                 out_imag_r;
  logic                                 out_last_r;

  // ---------------------------------------------------------------------
  // Combinational signals
  // ---------------------------------------------------------------------
  logic                 in_acc;
  logic                 frame_close;
  logic [K_W:0]         k_sum;
  logic [K_W-1:0]       k_nxt;
  ddft_pkg::twid_t      tw;
  logic signed [PW-1:0] prod_re;
  logic signed [PW-1:0] prod_im;
  logic [2*SW-1:0]      ram_rdata;
  logic [2*SW-1:0]      ram_wdata;
  logic signed [SW-1:0] old_re;
  logic signed [SW-1:0] old_im;
  logic signed [SW-1:0] re_new;
  logic signed [SW-1:0] im_new;
  logic signed [HALF_W:0] sc_hi;
  logic signed [HALF_W:0] sc_lo;

  function automatic logic signed [SW-1:0] sat_acc(input logic signed [SW:0] v);
    if (v[SW] != v[SW-1]) begin
      return v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return v[SW-1:0];
  endfunction

  // Combine the two half products, floor-shift by 31, saturate to 40 bits.
  function automatic logic signed [SW-1:0] scale_sat(input logic signed [MW-1:0] hi,
                                                     input logic signed [MW-1:0] lo);
    logic signed [TOT_W-1:0] tot;
    logic signed [TOT_W-1:0] sh;
    tot = (TOT_W'(hi) <<< HALF_W) + TOT_W'(lo);
    sh  = tot >>> ddft_pkg::OUT_SHIFT;
    if (!((&sh[TOT_W-1:SW-1]) || !(|sh[TOT_W-1:SW-1]))) begin
      return sh[TOT_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return sh[SW-1:0];
  endfunction

  assign busy        = (state_r != ST_IDLE) || s1_vld_r || s2_vld_r || s3_vld_r;
  assign in_acc      = start && !busy;
  assign frame_close = (n_r == CNT_W'(FRAME_POINTS));

  // Twiddle index walks by n each bin; k + n stays below 2*FRAME_POINTS.
  assign k_sum = {1'b0, k_r} + {1'b0, stride_r};
  assign k_nxt = (k_sum >= (K_W + 1)'(FRAME_POINTS)) ?
                 K_W'(k_sum - (K_W + 1)'(FRAME_POINTS)) : k_sum[K_W-1:0];

  // Read side: twiddle lookup and sample products.
  assign tw      = tw_tab[k_r];
  assign prod_re = PW'(sample_r) * PW'(tw.cos_v);
  assign prod_im = PW'(sample_r) * PW'(tw.sin_v);

  // Modify side: a bin never written since reset reads as zero.
  assign old_re = s1_ent_vld_r ? $signed(ram_rdata[2*SW-1:SW]) : '0;
  assign old_im = s1_ent_vld_r ? $signed(ram_rdata[SW-1:0])    : '0;
  assign re_new = sat_acc((SW + 1)'(old_re) + (SW + 1)'(s1_re_prod_r));
  assign im_new = sat_acc((SW + 1)'(old_im) - (SW + 1)'(s1_im_prod_r));

  // The frame-closing sample clears the bin on its way out.
  assign ram_wdata = frame_last_r ? '0 : {re_new, im_new};

  assign sc_hi = $signed({1'b0, scale_factor_r[ddft_pkg::SCALE_W-1:HALF_W]});
  assign sc_lo = $signed({1'b0, scale_factor_r[HALF_W-1:0]});

  // Bin store: real and imag sums side by side, one read and one write a cycle.
  // Write (stage 1, bin m-1) and read (bin m) never hit the same entry.
  ddft_ram #(
    .WIDTH (2 * SW),
    .DEPTH (BIN_COUNT)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_m_r),
    .wr_data (ram_wdata),
    .rd_addr (rd_m_r),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer, pipeline valids and configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      n_r            <= '0;
      rd_m_r         <= '0;
      k_r            <= '0;
      frame_last_r   <= 1'b0;
      mem_vld_r      <= '0;
      scale_factor_r <= ddft_pkg::SCALE_RESET;
      s1_vld_r       <= 1'b0;
      s2_vld_r       <= 1'b0;
      s3_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_factor_r <= cfg_wr_data;
      end
      s1_vld_r    <= (state_r == ST_RUN);
      s2_vld_r    <= s1_vld_r && frame_last_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
      if (s1_vld_r) begin
        mem_vld_r[s1_m_r] <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r      <= ST_RUN;
            rd_m_r       <= '0;
            k_r          <= '0;
            frame_last_r <= frame_close;
            n_r          <= frame_close ? '0 : n_r + CNT_W'(1);
          end
        end
        ST_RUN: begin
          rd_m_r <= rd_m_r + BIN_AW'(1);
          k_r    <= k_nxt;
          if (rd_m_r == BIN_AW'(BIN_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath pipeline
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample_value;
      stride_r <= frame_close ? '0 : K_W'(n_r);
    end
    // stage 1: products and read data
    s1_m_r       <= rd_m_r;
    s1_ent_vld_r <= mem_vld_r[rd_m_r];
    s1_re_prod_r <= prod_re;
    s1_im_prod_r <= prod_im;
    // stage 2: updated sums for readout
    s2_m_r  <= s1_m_r;
    s2_re_r <= re_new;
    s2_im_r <= im_new;
    // stage 3: scale half products
    s3_m_r     <= s2_m_r;
    s3_re_hi_r <= MW'(s2_re_r) * MW'(sc_hi);
    s3_re_lo_r <= MW'(s2_re_r) * MW'(sc_lo);
    s3_im_hi_r <= MW'(s2_im_r) * MW'(sc_hi);
    s3_im_lo_r <= MW'(s2_im_r) * MW'(sc_lo);
    // output register
    out_bin_index_r <= ddft_pkg::BIN_IDX_W'(s3_m_r);
    out_real_r      <= scale_sat(s3_re_hi_r, s3_re_lo_r);
    out_imag_r      <= scale_sat(s3_im_hi_r, s3_im_lo_r);
    out_last_r      <= (s3_m_r == BIN_AW'(BIN_COUNT - 1));
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_bin_index_r;
  assign out_real_part = out_real_r;
  assign out_imag_part = out_imag_r;
  assign out_last_bin  = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `DDFT_ASSERT_NOW(a_rmw_no_overlap, s1_vld_r && (state_r == ST_RUN), s1_m_r != rd_m_r, "bin RAM write and read hit the same entry")
  `DDFT_ASSERT_NOW(a_scale_on_close, s2_vld_r, frame_last_r, "scale stage busy outside a closing item")
  `DDFT_ASSERT_NEXT(a_readout_burst, out_valid_r && !out_last_r, out_valid_r, "bin readout burst broken before last bin")
  `DDFT_ASSERT_NEXT(a_busy_after_accept, in_acc, busy, "busy not raised after accepting a sample")

endmodule

### dv/dft_bin_checker.sv
// Result checker for the DFT bin accumulator: follows samples and scale writes, predicts bins.
module dft_bin_checker #(
  parameter int FRAME_POINTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                 cfg_wr_en,
  input  logic [ddft_pkg::SCALE_W-1:0]         cfg_wr_data,
  input  logic                                 out_valid,
  input  logic [ddft_pkg::BIN_IDX_W-1:0]       out_bin_index,
  input  logic signed [ddft_pkg::SUM_W-1:0]    out_real_part,
  input  logic signed [ddft_pkg::SUM_W-1:0]    out_imag_part,
  input  logic                                 out_last_bin,
  output int                                   fail_count,
  output int                                   pending
);

  localparam int     BINS        = FRAME_POINTS / 2;
  localparam int     ROT_STEPS   = 16;
  localparam longint SUM_MAX     = 64'sd549755813887;
  localparam longint SUM_MIN     = -64'sd549755813888;
  localparam longint ROT_X0      = 64'sd652032874;
  localparam logic [ddft_pkg::SCALE_W-1:0] UNITY_SCALE = 32'h0001_0000;
  // atan(2^-i) in 2^32 turns
  localparam longint ATAN_TURNS [ROT_STEPS] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
    64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
    64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
    64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D
  };

  typedef struct {
    logic [ddft_pkg::BIN_IDX_W-1:0]    bin;
    logic signed [ddft_pkg::SUM_W-1:0] re;
    logic signed [ddft_pkg::SUM_W-1:0] im;
    logic                              last;
  } bin_result_t;

  longint                       cos_tab [FRAME_POINTS];
  longint                       sin_tab [FRAME_POINTS];
  longint                       re_sum [BINS];
  longint                       im_sum [BINS];
  logic [ddft_pkg::SCALE_W-1:0] scale;
  int                           n_taken;
  int                           errors = 0;
  bin_result_t                  bins_due [$];

  function automatic longint clamp40(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  function automatic logic [31:0] phase_of(input int k);
    logic [63:0] wide;
    wide = ({32'(k), 32'd0} + 64'(FRAME_POINTS / 2)) / 64'(FRAME_POINTS);
    return wide[31:0];
  endfunction

  // Fold into +-1/8 turn, rotate, then unfold by quadrant.
  function automatic void rotate_phase(input logic [31:0] phase, output longint c,
                                       output longint s);
    logic [31:0] lifted;
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      z;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      xq;
    longint      yq;
    int          i;
    lifted = phase + 32'h2000_0000;
    quad   = lifted[31:30];
    resid  = phase - {quad, 30'd0};
    z      = longint'($signed(resid));
    x      = ROT_X0;
    y      = 64'sd0;
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    xq = round_q15(x);
    yq = round_q15(y);
    case (quad)
      2'd0: begin
        c = xq;
        s = yq;
      end
      2'd1: begin
        c = -yq;
        s = xq;
      end
      2'd2: begin
        c = -xq;
        s = -yq;
      end
      default: begin
        c = yq;
        s = -xq;
      end
    endcase
    if (c > 64'sd32767) c = 64'sd32767;
    if (s > 64'sd32767) s = 64'sd32767;
  endfunction

  // sum * scale / 2^31, floored, saturated to 40 bits
  function automatic longint scaled(input longint sum);
    logic signed [79:0] prod;
    prod = 80'(sum) * $signed({48'd0, scale});
    prod = prod >>> 31;
    if (prod > SUM_MAX) return SUM_MAX;
    if (prod < SUM_MIN) return SUM_MIN;
    return longint'(prod);
  endfunction

  function automatic void take_sample(input logic signed [ddft_pkg::SAMPLE_W-1:0] raw);
    longint      x;
    int          k;
    bin_result_t r;
    x = longint'(raw);
    for (int m = 0; m < BINS; m++) begin
      k = (m * n_taken) % FRAME_POINTS;
      re_sum[m] = clamp40(re_sum[m] + x * cos_tab[k]);
      im_sum[m] = clamp40(im_sum[m] - x * sin_tab[k]);
    end
    if (n_taken >= FRAME_POINTS) begin
      for (int m = 0; m < BINS; m++) begin
        r.bin  = ddft_pkg::BIN_IDX_W'(m);
        r.re   = ddft_pkg::SUM_W'(scaled(re_sum[m]));
        r.im   = ddft_pkg::SUM_W'(scaled(im_sum[m]));
        r.last = (m == BINS - 1);
        bins_due.push_back(r);
        re_sum[m] = 0;
        im_sum[m] = 0;
      end
      n_taken = 0;
    end else begin
      n_taken++;
    end
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    for (int k = 0; k < FRAME_POINTS; k++) rotate_phase(phase_of(k), cos_tab[k], sin_tab[k]);
  end

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst_n) begin
      scale   = UNITY_SCALE;
      n_taken = 0;
      for (int m = 0; m < BINS; m++) begin
        re_sum[m] = 0;
        im_sum[m] = 0;
      end
      bins_due.delete();
    end else begin
      if (out_valid) begin
        if (bins_due.size() == 0) begin
          $error("unexpected result for bin %0d", out_bin_index);
          errors++;
        end else begin
          want = bins_due.pop_front();
          check_field("bin_index", want.bin, out_bin_index);
          check_field("real_part", want.re, out_real_part);
          check_field("imag_part", want.im, out_imag_part);
          check_field("last_bin", want.last, out_last_bin);
        end
      end
      if (cfg_wr_en) scale = cfg_wr_data;
      if (start && !busy) take_sample(in_sample_value);
    end
    fail_count <= errors;
    pending    <= bins_due.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top for the DFT bin accumulator: clock, reset, sample stimulus, scale writes, verdict.
module tb_top;

  localparam int FRAME_POINTS = ddft_pkg::FRAME_POINTS_DEF;
  // One frame is FRAME_POINTS+1 samples; the last one triggers the readout.
  localparam int FRAME_LEN    = FRAME_POINTS + 1;
  localparam int FRAMES       = 3;
  // Item budget: two full frames and the opening of a third.
  localparam int ITEMS        = 160;
  // Margin past the closing sample's bin pass plus scale pipeline.
  localparam int SETTLE       = FRAME_POINTS / 2 + 8;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [ddft_pkg::SAMPLE_W-1:0] RAIL_HI = 16'sh7FFF;
  localparam logic signed [ddft_pkg::SAMPLE_W-1:0] RAIL_LO = 16'sh8000;

  // Directed opening of frame 0: rails, zero, +-1 LSB, checkerboards, half scale.
  localparam logic signed [ddft_pkg::SAMPLE_W-1:0] EDGE_SAMPLES [10] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF,
    16'sh5555, 16'shAAAA, 16'sh4000, 16'shC000, 16'sh7FFF
  };

  // Content shape of a frame's samples.
  typedef enum {MODE_UNIFORM, MODE_RAIL, MODE_ALTERNATE, MODE_SMALL} pattern_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic signed [ddft_pkg::SAMPLE_W-1:0] in_sample_value = '0;
  logic                                 cfg_wr_en = 1'b0;
  logic [ddft_pkg::SCALE_W-1:0]         cfg_wr_data = '0;
  logic                                 out_valid;
  logic [ddft_pkg::BIN_IDX_W-1:0]       out_bin_index;
  logic signed [ddft_pkg::SUM_W-1:0]    out_real_part;
  logic signed [ddft_pkg::SUM_W-1:0]    out_imag_part;
  logic                                 out_last_bin;
  int                                   fail_count;
  int                                   pending;
  int                                   cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  direct_dft_bin_accumulator_top #(
    .FRAME_POINTS(FRAME_POINTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_value(in_sample_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_bin_index  (out_bin_index),
    .out_real_part  (out_real_part),
    .out_imag_part  (out_imag_part),
    .out_last_bin   (out_last_bin)
  );

  // Watches both channels and the scale port, predicts every bin, compares.
  dft_bin_checker #(
    .FRAME_POINTS(FRAME_POINTS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample_value(in_sample_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_bin_index  (out_bin_index),
    .out_real_part  (out_real_part),
    .out_imag_part  (out_imag_part),
    .out_last_bin   (out_last_bin),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Watchdog: a hung handshake or a missing readout ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a longer one that may let the block go idle; none with no_idle.
  function automatic int pick_gap(input bit no_idle);
    if (no_idle) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [ddft_pkg::SAMPLE_W-1:0] next_sample(input pattern_t mode,
                                                                       input int idx,
                                                                       input bit neg);
    // Every pattern carries some uniform noise so all input bits keep toggling.
    if (mode == MODE_UNIFORM || $urandom_range(0, 7) == 0) begin
      return ddft_pkg::SAMPLE_W'($urandom);
    end
    case (mode)
      MODE_RAIL:      return neg ? RAIL_LO : RAIL_HI;
      MODE_ALTERNATE: return idx[0] ? RAIL_LO : RAIL_HI;
      default:        return ddft_pkg::SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  // Present one sample item after an optional gap and hold it until accepted.
  // With no gap, start simply stays high into the next item.
  task automatic push_sample(input logic signed [ddft_pkg::SAMPLE_W-1:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_sample_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Scale writes only land on an idle block: no bin pass running, no readout due.
  task automatic write_scale(input logic [ddft_pkg::SCALE_W-1:0] v);
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    pattern_t                             mode;
    bit                                   no_idle;
    bit                                   neg;
    int                                   sent;
    logic signed [ddft_pkg::SAMPLE_W-1:0] v;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame plan:
    //   0: reset scale (1.0), directed edges then uniform noise
    //   1: rail-held input, back to back; scale of one LSB rewritten
    //      mid-frame to max -> largest readouts
    //   2: random scale, alternating rails or small values, cut short by ITEMS
    sent = 0;
    for (int f = 0; f < FRAMES; f++) begin
      no_idle = (f == 1) || ($urandom_range(0, 3) == 0);
      neg     = 1'($urandom_range(0, 1));
      case (f)
        1: begin
          mode = MODE_RAIL;
          write_scale(32'h0000_0001);
        end
        2: begin
          mode = ($urandom_range(0, 1) == 0) ? MODE_ALTERNATE : MODE_SMALL;
          write_scale($urandom);
        end
        default: mode = MODE_UNIFORM;
      endcase
      for (int i = 0; i < FRAME_LEN && sent < ITEMS; i++) begin
        // Mid-frame write: bins already hold partial sums, readout uses the new scale.
        if (f == 1 && i == FRAME_LEN / 2) write_scale(32'hFFFF_FFFF);
        if (f == 0 && i < $size(EDGE_SAMPLES)) v = EDGE_SAMPLES[i];
        else v = next_sample(mode, i, neg);
        push_sample(v, pick_gap(no_idle));
        sent++;
      end
    end

    // Drain: wait for the last readout, then give stray results time to show.
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
